### src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, result codes and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;  // also "not a string start"
  localparam logic [2:0] ERR_NO_START  = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
  localparam logic [2:0] ERR_CTRL      = 3'd2;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd3;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd4;
  localparam logic [2:0] ERR_BAD_SURR  = 3'd5;

  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] err;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] r;
    logic [2:0]         n;
  } res_set_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] data, logic [2:0] err,
                                  logic last);
    res_t x;
    x.kind = kind;
    x.data = data;
    x.err  = err;
    x.last = last;
    return x;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b1, 4'(c - 8'h57)};
    return v;
  endfunction

  // code point to 1..4 UTF-8 bytes, lowest index goes out first
  function automatic res_set_t utf8_encode(logic [20:0] cp);
    res_set_t s;
    s = '0;
    if (cp[20:7] == '0) begin
      s.r[0] = mk_res(KIND_DATA, {1'b0, cp[6:0]}, ERR_NONE, 1'b1);
      s.n    = 3'd1;
    end else if (cp[20:11] == '0) begin
      s.r[0] = mk_res(KIND_DATA, {3'b110, cp[10:6]}, ERR_NONE, 1'b0);
      s.r[1] = mk_res(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE, 1'b1);
      s.n    = 3'd2;
    end else if (cp[20:16] == '0) begin
      s.r[0] = mk_res(KIND_DATA, {4'b1110, cp[15:12]}, ERR_NONE, 1'b0);
      s.r[1] = mk_res(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE, 1'b0);
      s.r[2] = mk_res(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE, 1'b1);
      s.n    = 3'd3;
    end else begin
      s.r[0] = mk_res(KIND_DATA, {5'b11110, cp[20:18]}, ERR_NONE, 1'b0);
      s.r[1] = mk_res(KIND_DATA, {2'b10, cp[17:12]}, ERR_NONE, 1'b0);
      s.r[2] = mk_res(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE, 1'b0);
      s.r[3] = mk_res(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE, 1'b1);
      s.n    = 3'd4;
    end
    return s;
  endfunction

endpackage

### src/json_string_unescape_utf8_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// Byte-serial JSON string unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Input: one text byte per word on in_byte (valid/stall), starting with the
// opening quote. Output: one result word per cycle while out_stall is low, on
// out_kind/out_byte/out_error_code/out_last_of_run; out_last_of_run marks the
// final word caused by an input byte. Bytes that cause no word (opening quote,
// backslash, u, hex digits that do not complete a code point) produce nothing on the output.
// Latency: results of a byte appear on the output the cycle after it is
// accepted. Throughput: one input byte per cycle while each byte yields at
// most one word and the output is not stalled; a \u escape that yields an
// n-byte UTF-8 run stalls the input while the single output port drains the run
// from the 4-entry result buffer. The next byte is taken in the same cycle
// the last buffered word leaves.
// Reset (rst_n low, synchronous): buffer empty, decoder waits for a quote.
// Output stall: buffered words hold, and the input is stalled while the word
// on the port is stalled or more words wait behind it.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_error_code,
  output logic       out_last_of_run
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_STR  = 4'd1;
  localparam logic [3:0] ST_ESC  = 4'd2;
  localparam logic [3:0] ST_HEX0 = 4'd3;
  localparam logic [3:0] ST_HEX1 = 4'd4;
  localparam logic [3:0] ST_HEX2 = 4'd5;
  localparam logic [3:0] ST_HEX3 = 4'd6;
  localparam logic [3:0] ST_SBS  = 4'd7;
  localparam logic [3:0] ST_SU   = 4'd8;
  localparam logic [3:0] ST_LOW0 = 4'd9;
  localparam logic [3:0] ST_LOW1 = 4'd10;
  localparam logic [3:0] ST_LOW2 = 4'd11;
  localparam logic [3:0] ST_LOW3 = 4'd12;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic [3:0]  mode_r, mode_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [9:0]  high_r, high_nxt;

  jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0] rbuf_r, rbuf_nxt;
  logic [2:0]  cnt_r, cnt_nxt;

  jsu_pkg::res_set_t rs;
  jsu_pkg::res_set_t enc;
  logic [4:0]  hexv;
  logic [15:0] hex_sh;
  logic [20:0] cp;
  logic        in_acc, out_acc;

  assign out_valid = (cnt_r != 3'd0);
  assign in_stall  = !((cnt_r == 3'd0) || ((cnt_r == 3'd1) && !out_stall));
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  assign out_kind        = rbuf_r[0].kind;
  assign out_byte        = rbuf_r[0].data;
  assign out_error_code  = rbuf_r[0].err;
  assign out_last_of_run = rbuf_r[0].last;

  assign hexv   = jsu_pkg::hex_value(in_byte);
  assign hex_sh = {hex_r[11:0], hexv[3:0]};

  // code point selection: plain unit, or surrogate pair joined
  always_comb begin
    if (mode_r == ST_LOW3) begin
      cp = {1'b0, high_r, hex_sh[9:0]} + 21'h10000;
    end else begin
      cp = {5'd0, hex_sh};
    end
    enc = jsu_pkg::utf8_encode(cp);
  end

  always_comb begin
    mode_nxt = mode_r;
    hex_nxt  = hex_r;
    high_nxt = high_r;
    rs       = '0;
    unique case (mode_r) inside
      ST_STR: begin
        if (in_byte == CH_QUOTE) begin
          rs.r[0]  = jsu_pkg::mk_res(jsu_pkg::KIND_END, 8'h00, jsu_pkg::ERR_NONE, 1'b1);
          rs.n     = 3'd1;
          mode_nxt = ST_IDLE;
        end else if (in_byte == 8'h00) begin
          rs.r[0]  = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_NO_QUOTE, 1'b1);
          rs.n     = 3'd1;
          mode_nxt = ST_IDLE;
        end else if (in_byte == CH_BSL) begin
          mode_nxt = ST_ESC;
        end else if (in_byte < CH_SPACE) begin
          rs.r[0]  = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_CTRL, 1'b1);
          rs.n     = 3'd1;
          mode_nxt = ST_IDLE;
        end else begin
          rs.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, in_byte, jsu_pkg::ERR_NONE, 1'b1);
          rs.n    = 3'd1;
        end
      end
      ST_ESC: begin
        rs.n     = 3'd1;
        mode_nxt = ST_STR;
        unique case (in_byte) inside
          CH_QUOTE, CH_BSL, CH_SLASH:
            rs.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, in_byte, jsu_pkg::ERR_NONE, 1'b1);
          CH_B: rs.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, 8'h08, jsu_pkg::ERR_NONE, 1'b1);
          CH_F: rs.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, 8'h0C, jsu_pkg::ERR_NONE, 1'b1);
          CH_N: rs.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, 8'h0A, jsu_pkg::ERR_NONE, 1'b1);
          CH_R: rs.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, 8'h0D, jsu_pkg::ERR_NONE, 1'b1);
          CH_T: rs.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, 8'h09, jsu_pkg::ERR_NONE, 1'b1);
          CH_U: begin
            rs.n     = 3'd0;
            hex_nxt  = 16'h0000;
            mode_nxt = ST_HEX0;
          end
          default: begin
            rs.r[0]  = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_ESC, 1'b1);
            mode_nxt = ST_IDLE;
          end
        endcase
      end
      ST_HEX0, ST_HEX1, ST_HEX2, ST_HEX3: begin
        if (!hexv[4]) begin
          rs.r[0]  = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_HEX, 1'b1);
          rs.n     = 3'd1;
          mode_nxt = ST_IDLE;
        end else begin
          hex_nxt = hex_sh;
          if (mode_r == ST_HEX3) begin
            // high surrogate D800..DBFF: top six bits 110110
            if (hex_sh[15:10] == 6'b110110) begin
              high_nxt = hex_sh[9:0];
              mode_nxt = ST_SBS;
            end else begin
              rs       = enc;
              mode_nxt = ST_STR;
            end
          end else begin
            mode_nxt = mode_r + 4'd1;
          end
        end
      end
      ST_SBS: begin
        if (in_byte == CH_BSL) begin
          mode_nxt = ST_SU;
        end else begin
          rs.r[0]  = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_SURR, 1'b1);
          rs.n     = 3'd1;
          mode_nxt = ST_IDLE;
        end
      end
      ST_SU: begin
        if (in_byte == CH_U) begin
          hex_nxt  = 16'h0000;
          mode_nxt = ST_LOW0;
        end else begin
          rs.r[0]  = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_SURR, 1'b1);
          rs.n     = 3'd1;
          mode_nxt = ST_IDLE;
        end
      end
      ST_LOW0, ST_LOW1, ST_LOW2, ST_LOW3: begin
        if (!hexv[4]) begin
          rs.r[0]  = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_HEX, 1'b1);
          rs.n     = 3'd1;
          mode_nxt = ST_IDLE;
        end else begin
          hex_nxt = hex_sh;
          if (mode_r == ST_LOW3) begin
            // low surrogate DC00..DFFF: top six bits 110111
            if (hex_sh[15:10] != 6'b110111) begin
              rs.r[0]  = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_SURR,
                                         1'b1);
              rs.n     = 3'd1;
              mode_nxt = ST_IDLE;
            end else begin
              rs       = enc;
              mode_nxt = ST_STR;
            end
          end else begin
            mode_nxt = mode_r + 4'd1;
          end
        end
      end
      default: begin
        // idle, and unused codes behave as idle
        if (in_byte == CH_QUOTE) begin
          mode_nxt = ST_STR;
        end else begin
          rs.r[0]  = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_NO_START, 1'b1);
          rs.n     = 3'd1;
          mode_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // result buffer: load on accept (buffer drains this cycle), else shift on pop
  always_comb begin
    rbuf_nxt = rbuf_r;
    cnt_nxt  = cnt_r;
    if (in_acc) begin
      rbuf_nxt = rs.r;
      cnt_nxt  = rs.n;
    end else if (out_acc) begin
      for (int i = 0; i < jsu_pkg::MAX_RES - 1; i++) begin
        rbuf_nxt[i] = rbuf_r[i+1];
      end
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ST_IDLE;
      hex_r  <= 16'h0000;
      high_r <= 10'd0;
      cnt_r  <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        mode_r <= mode_nxt;
        hex_r  <= hex_nxt;
        high_r <= high_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    rbuf_r <= rbuf_nxt;
  end

  // a non-final word always has its successor already buffered
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("run broken after non-final word");

  // end and error words close their run
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != jsu_pkg::KIND_DATA |-> out_last_of_run)
    else $error("end/error word not marked last");

  // error code only carried by error words
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != jsu_pkg::KIND_ERR |-> out_error_code == jsu_pkg::ERR_NONE)
    else $error("error code on non-error word");

  // no new byte while more than one word is still buffered
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r > 3'd1 |-> in_stall)
    else $error("input taken over pending run");

endmodule
